### src/hfe_pkg.sv
package hfe_pkg;

   // Default window geometry.
   localparam int DEF_WIN_WIDTH  = 24;
   localparam int DEF_WIN_HEIGHT = 24;

   // Field widths of the request and response payloads.
   localparam int PIXEL_W = 8;
   localparam int KIND_W  = 3;
   localparam int POS_W   = 5;
   localparam int SIZE_W  = 5;
   localparam int VALUE_W = 20;

   // Width of one offset (up to three cells) and of one corner coordinate.
   localparam int OFS_W = SIZE_W + 2;
   localparam int CRD_W = OFS_W + 1;

   // Request actions.
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_EVAL = 1'b1;

   // Feature kinds.
   localparam logic [KIND_W-1:0] KIND_TWO_WIDE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TWO_TALL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_THREE_WIDE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_THREE_TALL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TWO_BY_TWO = 3'd4;

   // Corner offset codes: how many cells away from the feature origin.
   localparam logic [1:0] OFS_NONE  = 2'd0;
   localparam logic [1:0] OFS_ONE   = 2'd1;
   localparam logic [1:0] OFS_TWO   = 2'd2;
   localparam logic [1:0] OFS_THREE = 2'd3;

   // Corner weights.
   localparam int COEF_W = 3;
   localparam logic signed [COEF_W-1:0] COEF_NEG3 = 3'sb101;
   localparam logic signed [COEF_W-1:0] COEF_NEG2 = 3'sb110;
   localparam logic signed [COEF_W-1:0] COEF_NEG1 = 3'sb111;
   localparam logic signed [COEF_W-1:0] COEF_POS1 = 3'sb001;
   localparam logic signed [COEF_W-1:0] COEF_POS2 = 3'sb010;
   localparam logic signed [COEF_W-1:0] COEF_POS3 = 3'sb011;

   // Microcode program counter and the entry point of each feature kind.
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_TWO_WIDE   = 5'd0;
   localparam logic [PC_W-1:0] PC_TWO_TALL   = 5'd3;
   localparam logic [PC_W-1:0] PC_THREE_WIDE = 5'd6;
   localparam logic [PC_W-1:0] PC_THREE_TALL = 5'd10;
   localparam logic [PC_W-1:0] PC_TWO_BY_TWO = 5'd14;

   typedef struct packed {
      logic               action;
      logic [PIXEL_W-1:0] pixel;
      logic [KIND_W-1:0]  feature_kind;
      logic [POS_W-1:0]   x_pos;
      logic [POS_W-1:0]   y_pos;
      logic [SIZE_W-1:0]  cell_width;
      logic [SIZE_W-1:0]  cell_height;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] feature_value;
      logic                      geometry_error;
   } rsp_payload_type;

   // One control word: two corner reads, each with its x and y offset code and weight.
   typedef struct packed {
      logic [1:0]               a_x;
      logic [1:0]               a_y;
      logic signed [COEF_W-1:0] a_coef;
      logic [1:0]               b_x;
      logic [1:0]               b_y;
      logic signed [COEF_W-1:0] b_coef;
      logic                     last;
   } ucode_word_type;

   // Extent of a feature in cells along each axis.
   typedef struct packed {
      logic [1:0] x_cells;
      logic [1:0] y_cells;
   } span_type;

   // Width of one summed-area table entry for a given window.
   function automatic int integ_bits(input int win_w, input int win_h);
      return $clog2(win_w * win_h * 255 + 1);
   endfunction

   function automatic ucode_word_type make_word(
      input logic [1:0] ax, input logic [1:0] ay, input logic signed [COEF_W-1:0] ac,
      input logic [1:0] bx, input logic [1:0] by, input logic signed [COEF_W-1:0] bc,
      input logic lst);
      ucode_word_type w;
      w.a_x    = ax;
      w.a_y    = ay;
      w.a_coef = ac;
      w.b_x    = bx;
      w.b_y    = by;
      w.b_coef = bc;
      w.last   = lst;
      return w;
   endfunction

   // The microprogram. Corner weights of overlapping rectangles are merged, so
   // each kind reads every distinct corner once (the centre of two-by-two twice).
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      case (pc)
         // Two cells side by side.
         5'd0:  w = make_word(OFS_NONE, OFS_NONE, COEF_NEG1, OFS_NONE, OFS_ONE, COEF_POS1, 1'b0);
         5'd1:  w = make_word(OFS_ONE, OFS_NONE, COEF_POS2, OFS_ONE, OFS_ONE, COEF_NEG2, 1'b0);
         5'd2:  w = make_word(OFS_TWO, OFS_NONE, COEF_NEG1, OFS_TWO, OFS_ONE, COEF_POS1, 1'b1);
         // Two cells stacked.
         5'd3:  w = make_word(OFS_NONE, OFS_NONE, COEF_NEG1, OFS_ONE, OFS_NONE, COEF_POS1, 1'b0);
         5'd4:  w = make_word(OFS_NONE, OFS_ONE, COEF_POS2, OFS_ONE, OFS_ONE, COEF_NEG2, 1'b0);
         5'd5:  w = make_word(OFS_NONE, OFS_TWO, COEF_NEG1, OFS_ONE, OFS_TWO, COEF_POS1, 1'b1);
         // Three cells side by side.
         5'd6:  w = make_word(OFS_NONE, OFS_NONE, COEF_NEG1, OFS_THREE, OFS_NONE, COEF_POS1,
                              1'b0);
         5'd7:  w = make_word(OFS_NONE, OFS_ONE, COEF_POS1, OFS_THREE, OFS_ONE, COEF_NEG1, 1'b0);
         5'd8:  w = make_word(OFS_ONE, OFS_NONE, COEF_POS3, OFS_TWO, OFS_NONE, COEF_NEG3, 1'b0);
         5'd9:  w = make_word(OFS_ONE, OFS_ONE, COEF_NEG3, OFS_TWO, OFS_ONE, COEF_POS3, 1'b1);
         // Three cells stacked.
         5'd10: w = make_word(OFS_NONE, OFS_NONE, COEF_NEG1, OFS_ONE, OFS_NONE, COEF_POS1, 1'b0);
         5'd11: w = make_word(OFS_NONE, OFS_THREE, COEF_POS1, OFS_ONE, OFS_THREE, COEF_NEG1,
                              1'b0);
         5'd12: w = make_word(OFS_NONE, OFS_ONE, COEF_POS3, OFS_ONE, OFS_ONE, COEF_NEG3, 1'b0);
         5'd13: w = make_word(OFS_NONE, OFS_TWO, COEF_NEG3, OFS_ONE, OFS_TWO, COEF_POS3, 1'b1);
         // Two by two.
         5'd14: w = make_word(OFS_NONE, OFS_NONE, COEF_POS1, OFS_TWO, OFS_NONE, COEF_POS1, 1'b0);
         5'd15: w = make_word(OFS_NONE, OFS_TWO, COEF_POS1, OFS_TWO, OFS_TWO, COEF_POS1, 1'b0);
         5'd16: w = make_word(OFS_ONE, OFS_NONE, COEF_NEG2, OFS_NONE, OFS_ONE, COEF_NEG2, 1'b0);
         5'd17: w = make_word(OFS_ONE, OFS_ONE, COEF_POS2, OFS_ONE, OFS_ONE, COEF_POS2, 1'b0);
         5'd18: w = make_word(OFS_TWO, OFS_ONE, COEF_NEG2, OFS_ONE, OFS_TWO, COEF_NEG2, 1'b1);
         default: w = make_word(OFS_NONE, OFS_NONE, COEF_POS1, OFS_NONE, OFS_NONE, COEF_POS1,
                                1'b1);
      endcase
      return w;
   endfunction

   function automatic logic [PC_W-1:0] entry_point(input logic [KIND_W-1:0] kind);
      logic [PC_W-1:0] pc;
      case (kind)
         KIND_TWO_WIDE:   pc = PC_TWO_WIDE;
         KIND_TWO_TALL:   pc = PC_TWO_TALL;
         KIND_THREE_WIDE: pc = PC_THREE_WIDE;
         KIND_THREE_TALL: pc = PC_THREE_TALL;
         KIND_TWO_BY_TWO: pc = PC_TWO_BY_TWO;
         default:         pc = PC_TWO_WIDE;
      endcase
      return pc;
   endfunction

   function automatic span_type feature_span(input logic [KIND_W-1:0] kind);
      span_type s;
      case (kind)
         KIND_TWO_WIDE:   begin s.x_cells = OFS_TWO;   s.y_cells = OFS_ONE;   end
         KIND_TWO_TALL:   begin s.x_cells = OFS_ONE;   s.y_cells = OFS_TWO;   end
         KIND_THREE_WIDE: begin s.x_cells = OFS_THREE; s.y_cells = OFS_ONE;   end
         KIND_THREE_TALL: begin s.x_cells = OFS_ONE;   s.y_cells = OFS_THREE; end
         KIND_TWO_BY_TWO: begin s.x_cells = OFS_TWO;   s.y_cells = OFS_TWO;   end
         default:         begin s.x_cells = OFS_NONE;  s.y_cells = OFS_NONE;  end
      endcase
      return s;
   endfunction

   // Multiplies a table value by a corner weight, modulo the result width.
   function automatic logic [VALUE_W-1:0] weigh(input logic [VALUE_W-1:0] value,
                                                input logic signed [COEF_W-1:0] coef);
      logic [COEF_W-1:0] mag;
      logic [VALUE_W-1:0] prod;
      mag = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);
      case (mag)
         3'd1:    prod = value;
         3'd2:    prod = value << 1;
         3'd3:    prod = value + (value << 1);
         default: prod = '0;
      endcase
      return coef[COEF_W-1] ? VALUE_W'(-prod) : prod;
   endfunction

endpackage

### src/hfe_stream_if.sv
interface hfe_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/hfe_store.sv
module hfe_store #(
   parameter int WIN_WIDTH  = hfe_pkg::DEF_WIN_WIDTH,
   parameter int WIN_HEIGHT = hfe_pkg::DEF_WIN_HEIGHT,
   localparam int ADDR_W  = $clog2((WIN_WIDTH + 1) * (WIN_HEIGHT + 1)),
   localparam int INTEG_W = hfe_pkg::integ_bits(WIN_WIDTH, WIN_HEIGHT)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   input  logic [hfe_pkg::PIXEL_W-1:0] load_pixel,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [INTEG_W-1:0]          rd_data_a,
   output logic [INTEG_W-1:0]          rd_data_b
);
   import hfe_pkg::*;

   localparam int STRIDE    = WIN_WIDTH + 1;
   localparam int TBL_DEPTH = (WIN_WIDTH + 1) * (WIN_HEIGHT + 1);
   localparam int COL_W     = $clog2(WIN_WIDTH + 1);
   localparam int ROW_W     = $clog2(WIN_HEIGHT + 1);
   localparam int RSUM_W    = $clog2(WIN_WIDTH * 255 + 1);

   logic [INTEG_W-1:0] mem [TBL_DEPTH];

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [RSUM_W-1:0]  rsum_ff, rsum_in;
   // Entries of the previous row, oldest first: line_ff[0] is the entry just above.
   logic [INTEG_W-1:0] line_ff [WIN_WIDTH];

   logic [RSUM_W-1:0]  rsum_sum;
   logic [INTEG_W-1:0] above;
   logic [INTEG_W-1:0] integ_new;
   logic [ADDR_W-1:0]  wr_addr;

   always_comb begin
      rsum_sum  = rsum_ff + RSUM_W'(load_pixel);
      above     = (row_ff == '0) ? '0 : line_ff[0];
      integ_new = above + INTEG_W'(rsum_sum);
      wr_addr   = ADDR_W'(row_ff) * ADDR_W'(STRIDE) + ADDR_W'(STRIDE)
                + ADDR_W'(col_ff) + ADDR_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      rsum_in = rsum_ff;
      if (load_valid) begin
         if (col_ff == COL_W'(WIN_WIDTH - 1)) begin
            col_in  = '0;
            rsum_in = '0;
            row_in  = (row_ff == ROW_W'(WIN_HEIGHT - 1)) ? '0 : ROW_W'(row_ff + 1'b1);
         end else begin
            col_in  = COL_W'(col_ff + 1'b1);
            rsum_in = rsum_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         rsum_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         rsum_ff <= rsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         for (int i = 0; i < WIN_WIDTH - 1; i++) begin
            line_ff[i] <= line_ff[i + 1];
         end
         line_ff[WIN_WIDTH - 1] <= integ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         mem[wr_addr] <= integ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### src/haar_feature_evaluator.sv
// Load request: no response; the next request may follow at once.
// Evaluate request: a microprogram of three to five steps reads two table corners per
// step through the dual-ported store; a drain state then empties the read stage, and the
// done state waits for a free response slot before a new request is taken.
// A feature that does not fit skips to the done state. Synchronous active-high reset clears
// the sequencer, load position and response slot; the table itself is never cleared.
module haar_feature_evaluator #(
   parameter int WIN_WIDTH  = hfe_pkg::DEF_WIN_WIDTH,
   parameter int WIN_HEIGHT = hfe_pkg::DEF_WIN_HEIGHT
) (
   input logic          clock,
   input logic          reset,
   hfe_stream_if.sink   req_chan,
   hfe_stream_if.source rsp_chan
);
   import hfe_pkg::*;

   localparam int STRIDE    = WIN_WIDTH + 1;
   localparam int TBL_DEPTH = (WIN_WIDTH + 1) * (WIN_HEIGHT + 1);
   localparam int ADDR_W    = $clog2(TBL_DEPTH);
   localparam int INTEG_W   = integ_bits(WIN_WIDTH, WIN_HEIGHT);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Picks one of the three cell multiples by offset code.
   function automatic logic [OFS_W-1:0] pick(input logic [1:0] code,
                                             input logic [OFS_W-1:0] one,
                                             input logic [OFS_W-1:0] two,
                                             input logic [OFS_W-1:0] three);
      logic [OFS_W-1:0] r;
      case (code)
         OFS_ONE:   r = one;
         OFS_TWO:   r = two;
         OFS_THREE: r = three;
         default:   r = '0;
      endcase
      return r;
   endfunction

   req_payload_type req;

   logic [1:0]       state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic             ok_ff, ok_in;

   // Feature origin and the one, two and three cell multiples of its cell size.
   logic [POS_W-1:0] x_ff, y_ff;
   logic [OFS_W-1:0] w1_ff, w2_ff, w3_ff;
   logic [OFS_W-1:0] h1_ff, h2_ff, h3_ff;

   // Read stage: weights and border flags travel alongside the registered store reads.
   logic                     stage_valid_ff;
   logic signed [COEF_W-1:0] coef_a_ff, coef_b_ff;
   logic                     zero_a_ff, zero_b_ff;
   logic [VALUE_W-1:0]       acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic                     req_ready;
   logic                     req_fire;
   logic                     load_fire;
   logic                     eval_fire;
   logic                     fits;
   logic                     kind_known;
   span_type                 span;
   logic [OFS_W-1:0]         in_w1, in_w2, in_w3;
   logic [OFS_W-1:0]         in_h1, in_h2, in_h3;
   logic [CRD_W-1:0]         reach_x, reach_y;

   ucode_word_type           word;
   logic [CRD_W-1:0]         ax, ay, bx, by;
   logic [ADDR_W-1:0]        addr_a, addr_b;
   logic                     rd_en;
   logic [INTEG_W-1:0]       rd_data_a, rd_data_b;
   logic [VALUE_W-1:0]       val_a, val_b;
   logic                     slot_free;

   assign req                = req_chan.payload;
   assign req_ready          = (state_ff == ST_IDLE);
   assign req_chan.ready     = req_ready;
   assign req_fire           = req_chan.valid && req_ready;
   assign load_fire          = req_fire && (req.action == ACTION_LOAD);
   assign eval_fire          = req_fire && (req.action == ACTION_EVAL);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.payload   = rsp_ff;

   // Geometry check of an evaluate request: the kind must be known, both cell sizes nonzero
   // and the far edge of the feature must not pass the window's right or bottom edge.
   always_comb begin
      span       = feature_span(req.feature_kind);
      kind_known = req.feature_kind inside {[KIND_TWO_WIDE:KIND_TWO_BY_TWO]};
      in_w1      = OFS_W'(req.cell_width);
      in_w2      = OFS_W'(in_w1 << 1);
      in_w3      = OFS_W'(in_w1 + in_w2);
      in_h1      = OFS_W'(req.cell_height);
      in_h2      = OFS_W'(in_h1 << 1);
      in_h3      = OFS_W'(in_h1 + in_h2);
      reach_x    = CRD_W'(req.x_pos) + CRD_W'(pick(span.x_cells, in_w1, in_w2, in_w3));
      reach_y    = CRD_W'(req.y_pos) + CRD_W'(pick(span.y_cells, in_h1, in_h2, in_h3));
      fits       = kind_known && (req.cell_width != '0) && (req.cell_height != '0)
                && (reach_x <= CRD_W'(WIN_WIDTH)) && (reach_y <= CRD_W'(WIN_HEIGHT));
   end

   // Corner addresses for the current microcode step. Only reached when the feature fits,
   // so every coordinate lies within the table.
   always_comb begin
      word   = ucode_rom(pc_ff);
      ax     = CRD_W'(x_ff) + CRD_W'(pick(word.a_x, w1_ff, w2_ff, w3_ff));
      ay     = CRD_W'(y_ff) + CRD_W'(pick(word.a_y, h1_ff, h2_ff, h3_ff));
      bx     = CRD_W'(x_ff) + CRD_W'(pick(word.b_x, w1_ff, w2_ff, w3_ff));
      by     = CRD_W'(y_ff) + CRD_W'(pick(word.b_y, h1_ff, h2_ff, h3_ff));
      addr_a = ADDR_W'(ay) * ADDR_W'(STRIDE) + ADDR_W'(ax);
      addr_b = ADDR_W'(by) * ADDR_W'(STRIDE) + ADDR_W'(bx);
      rd_en  = (state_ff == ST_ISSUE);
   end

   // Sequencer: dispatch jumps to the kind's entry point, or straight to the answer when
   // the geometry is bad; steps run until the word marked last, then a drain state empties the
   // read stage before the result is offered.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      ok_in    = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_fire) begin
               ok_in    = fits;
               pc_in    = entry_point(req.feature_kind);
               state_in = fits ? ST_ISSUE : ST_DONE;
            end
         end
         ST_ISSUE: begin
            if (word.last) begin
               state_in = ST_DRAIN;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Accumulator: the border row and column of the table read as zero.
   always_comb begin
      val_a  = zero_a_ff ? '0 : VALUE_W'(rd_data_a);
      val_b  = zero_b_ff ? '0 : VALUE_W'(rd_data_b);
      acc_in = acc_ff;
      if (eval_fire) begin
         acc_in = '0;
      end else if (stage_valid_ff) begin
         acc_in = acc_ff + weigh(val_a, coef_a_ff) + weigh(val_b, coef_b_ff);
      end
   end

   // Response slot: a finished result waits here while the next request is taken.
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if ((state_ff == ST_DONE) && slot_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.feature_value  = ok_ff ? acc_ff : '0;
         rsp_in.geometry_error = !ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pc_ff          <= '0;
         ok_ff          <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pc_ff          <= pc_in;
         ok_ff          <= ok_in;
         stage_valid_ff <= rd_en;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      if (eval_fire) begin
         x_ff  <= req.x_pos;
         y_ff  <= req.y_pos;
         w1_ff <= in_w1;
         w2_ff <= in_w2;
         w3_ff <= in_w3;
         h1_ff <= in_h1;
         h2_ff <= in_h2;
         h3_ff <= in_h3;
      end
      if (rd_en) begin
         coef_a_ff <= word.a_coef;
         coef_b_ff <= word.b_coef;
         zero_a_ff <= (ax == '0) || (ay == '0);
         zero_b_ff <= (bx == '0) || (by == '0);
      end
   end

   hfe_store #(
      .WIN_WIDTH  (WIN_WIDTH),
      .WIN_HEIGHT (WIN_HEIGHT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_fire),
      .load_pixel (req.pixel),
      .rd_en      (rd_en),
      .rd_addr_a  (addr_a),
      .rd_addr_b  (addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b)
   );

endmodule

### src/hfe_checker.sv
module hfe_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     req_action,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [hfe_pkg::VALUE_W-1:0]       rsp_value,
   input logic                                     rsp_error
);
   import hfe_pkg::*;

   // A response, once offered, stays until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   // Reset leaves the block ready and the response slot empty.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A geometry error always carries a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == '0)
      else $error("geometry error with nonzero value");

   // An evaluate request occupies the sequencer for at least the following cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACTION_EVAL) |=> !req_ready)
      else $error("request taken while an evaluation was starting");

   // A load request never occupies the sequencer.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACTION_LOAD) |=> req_ready)
      else $error("load request stalled the block");

endmodule

bind haar_feature_evaluator hfe_checker u_hfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_action (req_chan.payload.action),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.payload.feature_value),
   .rsp_error  (rsp_chan.payload.geometry_error)
);
